>>> sv/lvi_pkg.sv
// shared types, codes and the led colour table for the led and vibration indicator
package lvi_pkg;

   // request kinds
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_SET     = 2'd1;
   localparam logic [1:0] OP_VIBRATE = 2'd2;

   // csr register indexes
   localparam logic [2:0] CSR_BLINK_HALF    = 3'd0;
   localparam logic [2:0] CSR_PULSE_ON      = 3'd1;
   localparam logic [2:0] CSR_PULSE_OFF     = 3'd2;
   localparam logic [2:0] CSR_SUCCESS_HOLD  = 3'd3;
   localparam logic [2:0] CSR_REJECTED_HOLD = 3'd4;
   localparam logic [2:0] CSR_LED_POL       = 3'd5;
   localparam logic [2:0] CSR_MOTOR_POL     = 3'd6;

   localparam int unsigned CSR_DATA_W = 12;
   localparam int unsigned MS_W       = 10;
   localparam int unsigned HOLD_W     = 12;

   // csr reset values
   localparam logic [MS_W-1:0]   BLINK_HALF_RST    = 10'd250;
   localparam logic [MS_W-1:0]   PULSE_ON_RST      = 10'd120;
   localparam logic [MS_W-1:0]   PULSE_OFF_RST     = 10'd100;
   localparam logic [HOLD_W-1:0] SUCCESS_HOLD_RST  = 12'd1200;
   localparam logic [HOLD_W-1:0] REJECTED_HOLD_RST = 12'd2000;

   localparam logic [HOLD_W-1:0] ELAPSED_MAX = 12'd4095;

   typedef enum logic [2:0] {
      MODE_BOOT         = 3'd0,
      MODE_DISCONNECTED = 3'd1,
      MODE_IDLE         = 3'd2,
      MODE_SENDING      = 3'd3,
      MODE_URGENT       = 3'd4,
      MODE_SUCCESS      = 3'd5,
      MODE_FULL         = 3'd6,
      MODE_REJECTED     = 3'd7
   } mode_type;

   typedef struct packed {
      logic [1:0] op;
      logic       link_up;
      logic [2:0] new_mode;
      logic [3:0] pulse_count;
   } req_type;

   typedef struct packed {
      logic       red_pin;
      logic       green_pin;
      logic       blue_pin;
      logic       motor_pin;
      logic [2:0] mode_now;
      logic       vibrating;
   } rsp_type;

   // led levels: bit0 red, bit1 green, bit2 blue
   function automatic logic [2:0] draw_leds(input mode_type m, input logic lit);
      logic [2:0] lv;
      case (m)
         MODE_BOOT:         lv = 3'b100;
         MODE_DISCONNECTED: lv = lit ? 3'b011 : 3'b000;
         MODE_IDLE:         lv = 3'b010;
         MODE_SENDING:      lv = 3'b011;
         MODE_URGENT:       lv = lit ? 3'b001 : 3'b000;
         MODE_SUCCESS:      lv = {lit, 2'b10};
         MODE_FULL:         lv = 3'b101;
         default:           lv = lit ? 3'b101 : 3'b000;
      endcase
      return lv;
   endfunction

endpackage

>>> sv/led_and_vibration_indicator_top.sv
// led and vibration indicator: mode state, blink divider, pulse sequencer and result register
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_payload  (op, link_up, new_mode, pulse_count)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_payload  (pins, mode_now, vibrating)
//   csr     | in        | csr_we               | csr_index, csr_wdata
//
// one request per cycle while not stalled; its response is registered on acceptance
// throughput is set by the single result register: a request is taken whenever that register
//   is empty or is being drained in the same cycle
// a stalled response holds, and requests stall with it until rsp_ready returns
// synchronous reset restores the csr defaults, boot mode, all leds off and the motor stopped
module led_and_vibration_indicator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lvi_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lvi_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_we,
   input  logic [2:0]                        csr_index,
   input  logic [lvi_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lvi_pkg::*;

   // csr registers
   logic [MS_W-1:0]   blink_half_ff;
   logic [MS_W-1:0]   pulse_on_ff;
   logic [MS_W-1:0]   pulse_off_ff;
   logic [HOLD_W-1:0] success_hold_ff;
   logic [HOLD_W-1:0] rejected_hold_ff;
   logic              led_pol_ff;
   logic              motor_pol_ff;

   // indicator state
   mode_type          mode_ff, mode_in;
   logic [HOLD_W-1:0] elapsed_ff, elapsed_in;
   logic [MS_W-1:0]   blink_count_ff, blink_count_in;
   logic              blink_phase_ff, blink_phase_in;
   logic [2:0]        led_ff, led_in;
   logic              motor_ff, motor_in;
   logic [4:0]        edges_ff, edges_in;
   logic [MS_W-1:0]   edge_wait_ff, edge_wait_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              req_accept;
   logic [MS_W-1:0]   wait_dec;
   logic [MS_W-1:0]   reload;
   logic [MS_W-1:0]   blink_inc;
   logic [HOLD_W-1:0] elapsed_inc;
   logic              hold_done;

   // a result may leave in the same cycle a new request arrives
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      mode_in        = mode_ff;
      elapsed_in     = elapsed_ff;
      blink_count_in = blink_count_ff;
      blink_phase_in = blink_phase_ff;
      led_in         = led_ff;
      motor_in       = motor_ff;
      edges_in       = edges_ff;
      edge_wait_in   = edge_wait_ff;
      wait_dec       = (edge_wait_ff != '0) ? edge_wait_ff - 1'b1 : edge_wait_ff;
      reload         = '0;
      blink_inc      = blink_count_ff + 1'b1;
      elapsed_inc    = (elapsed_ff < ELAPSED_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
      hold_done      = 1'b0;

      if (req_accept) begin
         case (req_payload.op)
            OP_TICK: begin
               // pulse sequencer first
               edge_wait_in = wait_dec;
               if (edges_ff != '0 && wait_dec == '0) begin
                  motor_in = !motor_ff;
                  edges_in = edges_ff - 1'b1;
                  reload   = motor_in ? pulse_on_ff : pulse_off_ff;
                  // a zero time behaves as one millisecond
                  edge_wait_in = (reload == '0) ? MS_W'(1) : reload;
               end
               // free-running blink divider
               if (blink_inc >= blink_half_ff) begin
                  blink_count_in = '0;
                  blink_phase_in = !blink_phase_ff;
               end else begin
                  blink_count_in = blink_inc;
               end
               elapsed_in = elapsed_inc;
               // drawn from the mode before any timed return
               led_in = draw_leds(mode_ff, !blink_phase_in);
               hold_done = (mode_ff == MODE_SUCCESS  && elapsed_inc >= success_hold_ff) ||
                           (mode_ff == MODE_REJECTED && elapsed_inc >= rejected_hold_ff);
               if (hold_done) begin
                  mode_in    = req_payload.link_up ? MODE_IDLE : MODE_DISCONNECTED;
                  elapsed_in = '0;
               end
            end
            OP_SET: begin
               // same mode keeps its running time
               if (mode_type'(req_payload.new_mode) != mode_ff) begin
                  mode_in    = mode_type'(req_payload.new_mode);
                  elapsed_in = '0;
               end
            end
            OP_VIBRATE: begin
               // stop now, first edge on the next tick
               motor_in     = 1'b0;
               edges_in     = {req_payload.pulse_count, 1'b0};
               edge_wait_in = '0;
            end
            default: begin
            end
         endcase
      end

      // polarity applied on the way into the result register
      rsp_in.red_pin   = (led_in[0] == led_pol_ff);
      rsp_in.green_pin = (led_in[1] == led_pol_ff);
      rsp_in.blue_pin  = (led_in[2] == led_pol_ff);
      rsp_in.motor_pin = (motor_in == motor_pol_ff);
      rsp_in.mode_now  = mode_in;
      rsp_in.vibrating = (edges_in != '0);

      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         blink_half_ff    <= BLINK_HALF_RST;
         pulse_on_ff      <= PULSE_ON_RST;
         pulse_off_ff     <= PULSE_OFF_RST;
         success_hold_ff  <= SUCCESS_HOLD_RST;
         rejected_hold_ff <= REJECTED_HOLD_RST;
         led_pol_ff       <= 1'b1;
         motor_pol_ff     <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BLINK_HALF:    blink_half_ff    <= csr_wdata[MS_W-1:0];
            CSR_PULSE_ON:      pulse_on_ff      <= csr_wdata[MS_W-1:0];
            CSR_PULSE_OFF:     pulse_off_ff     <= csr_wdata[MS_W-1:0];
            CSR_SUCCESS_HOLD:  success_hold_ff  <= csr_wdata[HOLD_W-1:0];
            CSR_REJECTED_HOLD: rejected_hold_ff <= csr_wdata[HOLD_W-1:0];
            CSR_LED_POL:       led_pol_ff       <= csr_wdata[0];
            CSR_MOTOR_POL:     motor_pol_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // indicator state and result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_BOOT;
         elapsed_ff     <= '0;
         blink_count_ff <= '0;
         blink_phase_ff <= 1'b0;
         led_ff         <= '0;
         motor_ff       <= 1'b0;
         edges_ff       <= '0;
         edge_wait_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         elapsed_ff     <= elapsed_in;
         blink_count_ff <= blink_count_in;
         blink_phase_ff <= blink_phase_in;
         led_ff         <= led_in;
         motor_ff       <= motor_in;
         edges_ff       <= edges_in;
         edge_wait_ff   <= edge_wait_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload, loaded only with a new request
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a held response still describes the current state
   a_rsp_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.vibrating == (edges_ff != '0)) &&
                       (rsp_ff.mode_now == mode_ff))
      else $error("held response disagrees with state");

   // a change of mode restarts the elapsed time
   a_set_clears_elapsed: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_payload.op == OP_SET &&
       mode_type'(req_payload.new_mode) != mode_ff) |=> (elapsed_ff == '0))
      else $error("elapsed time not restarted on mode change");

   // state moves only with an accepted request
   a_state_idle: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(mode_ff) && $stable(edges_ff) && $stable(elapsed_ff))
      else $error("state changed without a request");

   // nothing is offered straight after reset
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid_ff)
      else $error("response valid after reset");

endmodule
